// ===== rtl/sfd_pkg.sv =====
// sfd_pkg: shared constants, register and mode codes, configuration struct
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAIN_DEPTH  = 131072;
  localparam int HAAS_DEPTH  = 2048;

  localparam int MAIN_AW = $clog2(MAIN_DEPTH);
  localparam int HAAS_AW = $clog2(HAAS_DEPTH);

  // two samples per word, padded up to whole bytes
  localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  localparam int PADDR_W = 5;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_LEFT_DLY = 3'd1;
  localparam logic [2:0] REG_RIGHT_DLY = 3'd2;
  localparam logic [2:0] REG_HAAS_DLY = 3'd3;
  localparam logic [2:0] REG_FB_GAIN  = 3'd4;
  localparam logic [2:0] REG_WET_MIX  = 3'd5;

  localparam logic [1:0] MODE_STEREO   = 2'd0;
  localparam logic [1:0] MODE_PINGPONG = 2'd1;
  localparam logic [1:0] MODE_HAAS     = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [16:0] left_delay;
    logic [16:0] right_delay;
    logic [10:0] haas_delay;
    logic [14:0] feedback_gain;
    logic [15:0] wet_mix;
  } cfg_t;

endpackage

// ===== rtl/sfd_ram.sv =====
// sfd_ram: single-port synchronous ram, registered read data
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/sfd_regs.sv =====
// sfd_regs: apb register file holding the delay configuration
`timescale 1ns / 1ps

module sfd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output sfd_pkg::cfg_t               cfg
);
  import sfd_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= MODE_STEREO;
      cfg.left_delay    <= 17'd24000;
      cfg.right_delay   <= 17'd24000;
      cfg.haas_delay    <= 11'd480;
      cfg.feedback_gain <= 15'd16384;
      cfg.wet_mix       <= 16'd16384;
    end else if (wr) begin
      unique case (idx)
        REG_MODE:      cfg.mode          <= pwdata[1:0];
        REG_LEFT_DLY:  cfg.left_delay    <= pwdata[16:0];
        REG_RIGHT_DLY: cfg.right_delay   <= pwdata[16:0];
        REG_HAAS_DLY:  cfg.haas_delay    <= pwdata[10:0];
        REG_FB_GAIN:   cfg.feedback_gain <= pwdata[14:0];
        REG_WET_MIX:   cfg.wet_mix       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:      prdata = 32'(cfg.mode);
      REG_LEFT_DLY:  prdata = 32'(cfg.left_delay);
      REG_RIGHT_DLY: prdata = 32'(cfg.right_delay);
      REG_HAAS_DLY:  prdata = 32'(cfg.haas_delay);
      REG_FB_GAIN:   prdata = 32'(cfg.feedback_gain);
      REG_WET_MIX:   prdata = 32'(cfg.wet_mix);
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/sfd_core.sv =====
// sfd_core: delay line memories, read-modify-write sequencing, mix math, output buffer
`timescale 1ns / 1ps

module sfd_core (
  input  logic                        clk,
  input  logic                        rst,
  input  sfd_pkg::cfg_t               cfg,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [sfd_pkg::TDATA_W-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [sfd_pkg::TDATA_W-1:0] m_axis_tdata
);
  import sfd_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int PW    = SB + 18;
  localparam int MIX_W = PW + 1;
  localparam int SAT_W = MIX_W - 15;
  localparam int MDW   = (MAIN_AW > 17 ? MAIN_AW : 17) + 1;
  localparam int HDW   = (HAAS_AW > 11 ? HAAS_AW : 11) + 1;
  localparam logic [MAIN_AW-1:0] MAIN_LAST = MAIN_AW'(MAIN_DEPTH - 1);
  localparam logic [HAAS_AW-1:0] HAAS_LAST = HAAS_AW'(HAAS_DEPTH - 1);
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

  function automatic logic [MAIN_AW-1:0] main_rd(input logic [MAIN_AW-1:0] pos,
                                                 input logic [16:0] d);
    logic [MDW-1:0] dd;
    logic [MDW-1:0] diff;
    dd = MDW'(d);
    if (dd >= MDW'(MAIN_DEPTH)) dd = MDW'(MAIN_DEPTH - 1);
    diff = MDW'(pos) - dd;
    if (diff[MDW-1]) diff = diff + MDW'(MAIN_DEPTH);
    return diff[MAIN_AW-1:0];
  endfunction

  function automatic logic [HAAS_AW-1:0] haas_rd(input logic [HAAS_AW-1:0] pos,
                                                 input logic [10:0] d);
    logic [HDW-1:0] dd;
    logic [HDW-1:0] diff;
    dd = HDW'(d);
    if (dd >= HDW'(HAAS_DEPTH)) dd = HDW'(HAAS_DEPTH - 1);
    diff = HDW'(pos) - dd;
    if (diff[HDW-1]) diff = diff + HDW'(HAAS_DEPTH);
    return diff[HAAS_AW-1:0];
  endfunction

  function automatic logic signed [SB-1:0] sat(input logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) return SAT_HI[SB-1:0];
    if (v < SAT_LO) return SAT_LO[SB-1:0];
    return v[SB-1:0];
  endfunction

  // control
  logic                s_acc, m_acc;
  logic                busy;
  logic [MAIN_AW-1:0]  wp;
  logic [HAAS_AW-1:0]  hp;
  logic                main_wrap, haas_wrap;
  logic                main_in, haas_in, main_q, haas_q;

  // per-word payload
  logic [1:0]          mode_q;
  logic signed [SB-1:0] xl_q, xr_q;
  logic                l_ok, r_ok, h_ok;

  logic [MAIN_AW-1:0]  rd_l, rd_r;
  logic [HAAS_AW-1:0]  rd_h;

  // memory ports
  logic                l_en, r_en, h_en;
  logic [MAIN_AW-1:0]  l_addr, r_addr;
  logic [HAAS_AW-1:0]  h_addr;
  logic [SB-1:0]       l_rdata, r_rdata, h_rdata;

  // datapath
  logic signed [SB-1:0]  dl, dr, dh, fl, fr, avg, mrx, mrd, ml, mr, wl, wr, yl, yr;
  logic signed [SB:0]    hsum;
  logic [15:0]           wet_c;
  logic signed [17:0]    wet_s, dry_s;
  logic signed [15:0]    gain_s;
  logic signed [PW-1:0]  pl_dry, pl_wet, pr_dry, pr_wet;
  logic signed [MIX_W-1:0] acc_l, acc_r;
  logic signed [SB+15:0] pfl, pfr, rfl, rfr;
  logic signed [SB:0]    fbl, fbr;
  logic signed [SAT_W-1:0] sl, sr;
  logic [TDATA_W-1:0]    res_data, hold_data;
  logic                  hold_valid, out_free;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  // each accept is followed by the write slot; hold buffer must be free
  assign s_axis_tready = !busy && !hold_valid;

  assign main_in = (cfg.mode == MODE_STEREO) || (cfg.mode == MODE_PINGPONG);
  assign haas_in = (cfg.mode == MODE_HAAS);
  assign main_q  = (mode_q == MODE_STEREO) || (mode_q == MODE_PINGPONG);
  assign haas_q  = (mode_q == MODE_HAAS);

  assign rd_l = main_rd(wp, cfg.left_delay);
  assign rd_r = main_rd(wp, cfg.right_delay);
  assign rd_h = haas_rd(hp, cfg.haas_delay);

  // read on accept, write back on the following cycle
  assign l_en   = (s_acc && main_in) || (busy && main_q);
  assign r_en   = l_en;
  assign h_en   = (s_acc && haas_in) || (busy && haas_q);
  assign l_addr = busy ? wp : rd_l;
  assign r_addr = busy ? wp : rd_r;
  assign h_addr = busy ? hp : rd_h;

  sfd_ram #(.DEPTH(MAIN_DEPTH), .WIDTH(SB)) u_left_line (
    .clk(clk), .en(l_en), .we(busy), .addr(l_addr), .wdata(wl), .rdata(l_rdata)
  );

  sfd_ram #(.DEPTH(MAIN_DEPTH), .WIDTH(SB)) u_right_line (
    .clk(clk), .en(r_en), .we(busy), .addr(r_addr), .wdata(wr), .rdata(r_rdata)
  );

  sfd_ram #(.DEPTH(HAAS_DEPTH), .WIDTH(SB)) u_haas_line (
    .clk(clk), .en(h_en), .we(busy), .addr(h_addr), .wdata(avg), .rdata(h_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      wp        <= '0;
      hp        <= '0;
      main_wrap <= 1'b0;
      haas_wrap <= 1'b0;
    end else begin
      busy <= s_acc;
      if (busy && main_q) begin
        wp <= (wp == MAIN_LAST) ? '0 : wp + 1'b1;
        if (wp == MAIN_LAST) main_wrap <= 1'b1;
      end
      if (busy && haas_q) begin
        hp <= (hp == HAAS_LAST) ? '0 : hp + 1'b1;
        if (hp == HAAS_LAST) haas_wrap <= 1'b1;
      end
    end
  end

  // entries not yet written since reset read as zero
  always_ff @(posedge clk) begin
    if (s_acc) begin
      xl_q   <= s_axis_tdata[SB-1:0];
      xr_q   <= s_axis_tdata[2*SB-1:SB];
      mode_q <= cfg.mode;
      l_ok   <= main_wrap || (rd_l < wp);
      r_ok   <= main_wrap || (rd_r < wp);
      h_ok   <= haas_wrap || (rd_h < hp);
    end
  end

  always_comb begin
    dl = l_ok ? l_rdata : '0;
    dr = r_ok ? r_rdata : '0;
    dh = h_ok ? h_rdata : '0;
    fl = (mode_q == MODE_PINGPONG) ? dr : dl;
    fr = (mode_q == MODE_PINGPONG) ? dl : dr;

    hsum = {xl_q[SB-1], xl_q} + {xr_q[SB-1], xr_q};
    avg  = hsum[SB:1];

    wet_c = (cfg.wet_mix > 16'd32768) ? 16'd32768 : cfg.wet_mix;
    wet_s = {2'b00, wet_c};
    dry_s = 18'sd32768 - wet_s;
    gain_s = {1'b0, cfg.feedback_gain};

    // feedback into the lines
    pfl = fl * gain_s;
    pfr = fr * gain_s;
    rfl = pfl + (SB + 16)'(16384);
    rfr = pfr + (SB + 16)'(16384);
    fbl = rfl[SB+15:15];
    fbr = rfr[SB+15:15];
    sl  = SAT_W'(xl_q) + SAT_W'(fbl);
    sr  = SAT_W'(xr_q) + SAT_W'(fbr);
    wl  = sat(sl);
    wr  = sat(sr);

    // right mixer is shared with the haas path
    mrx = haas_q ? avg : xr_q;
    mrd = haas_q ? dh : dr;
    pl_dry = xl_q * dry_s;
    pl_wet = dl * wet_s;
    pr_dry = mrx * dry_s;
    pr_wet = mrd * wet_s;
    acc_l  = MIX_W'(pl_dry) + MIX_W'(pl_wet) + MIX_W'(16384);
    acc_r  = MIX_W'(pr_dry) + MIX_W'(pr_wet) + MIX_W'(16384);
    ml = sat(acc_l[MIX_W-1:15]);
    mr = sat(acc_r[MIX_W-1:15]);

    yl = main_q ? ml : (haas_q ? avg : xl_q);
    yr = (main_q || haas_q) ? mr : xr_q;
    res_data = TDATA_W'({yr, yl});
  end

  // output register plus one hold word so a stalled result does not block input
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      hold_valid    <= 1'b0;
    end else if (busy) begin
      if (out_free) begin
        m_axis_tvalid <= 1'b1;
      end else begin
        hold_valid <= 1'b1;
      end
    end else if (m_acc) begin
      if (hold_valid) begin
        hold_valid <= 1'b0;
      end else begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (out_free) begin
        m_axis_tdata <= res_data;
      end else begin
        hold_data <= res_data;
      end
    end else if (m_acc && hold_valid) begin
      m_axis_tdata <= hold_data;
    end
  end

endmodule

// ===== rtl/stereo_feedback_delay.sv =====
// stereo_feedback_delay: top level, register file and delay core
//
//   channel   kind          payload
//   s_axis    stream in     tdata: left_in, right_in
//   m_axis    stream out    tdata: left_out, right_out
//   apb       config        six registers at byte address 4*i
//
// a new word is not taken while the last is written back: the accept cycle
// reads the single-port delay rams, the next cycle writes back the new line
// samples and loads the result into the output or the hold register.
// reset is synchronous; lines read as zero until written, tracked by the
// write position and a wrap flag, so no clearing pass is needed.
// a stalled output word waits in the output register while one more word
// is taken in; that next result parks in a hold register and input stalls
// until the hold register drains.
`timescale 1ns / 1ps

module stereo_feedback_delay (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [sfd_pkg::TDATA_W-1:0] s_axis_tdata,  // left_in, right_in
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [sfd_pkg::TDATA_W-1:0] m_axis_tdata   // left_out, right_out
);
  import sfd_pkg::*;

  cfg_t cfg;

  sfd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== rtl/sfd_checker.sv =====
// sfd_checker: port-level assertions for the delay block, bound to the top level
`timescale 1ns / 1ps

module sfd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [sfd_pkg::TDATA_W-1:0] m_axis_tdata
);
  import sfd_pkg::*;

  logic       s_acc, m_acc;
  logic [1:0] pending;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // words taken in and not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= 2'(pending + 2'(s_acc) - 2'(m_acc));
    end
  end

  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_axis_tready)
    else $error("input accepted during write-back cycle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed or dropped");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 2'd0)
    else $error("output word without an input word");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("more words in flight than buffer space");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not empty and ready after reset");

endmodule

bind stereo_feedback_delay sfd_checker u_sfd_checker (.*);

// ===== tb/sv/stereo_delay_checker.sv =====
// stereo_delay_checker: mirrors the register writes, predicts every output word and compares it
`timescale 1ns / 1ps

module stereo_delay_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [sfd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [sfd_pkg::TDATA_W-1:0] s_axis_tdata,  // left_in, right_in
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [sfd_pkg::TDATA_W-1:0] m_axis_tdata,  // left_out, right_out
  output int                          errors,
  output int                          pending,
  output int                          checked
);
  import sfd_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t right;
    sample_t left;
  } pair_t;

  localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  cfg_t               cfg;
  sample_t            left_mem  [MAIN_DEPTH];
  sample_t            right_mem [MAIN_DEPTH];
  sample_t            haas_mem  [HAAS_DEPTH];
  logic [MAIN_AW-1:0] main_pos;
  logic [HAAS_AW-1:0] haas_pos;
  pair_t              expected_pairs [$];
  pair_t              want;
  pair_t              got;

  function automatic longint clip(longint v);
    return (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
  endfunction

  // scale by 2^-15, round half up
  function automatic longint round_q15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic longint blend(longint dry, longint wet_in, longint wet);
    return clip(round_q15(dry * (32768 - wet) + wet_in * wet));
  endfunction

  function automatic int tap(int pos, int dly, int depth);
    if (dly >= depth) dly = depth - 1;
    return (pos + depth - dly) % depth;
  endfunction

  // one stereo pair through the delay, advancing only the active mode's memory
  function pair_t process_pair(sample_t l_in, sample_t r_in);
    longint xl, xr, dl, dr, fl, fr, avg, dh, wet, gain;
    pair_t  y;
    xl = l_in;
    xr = r_in;
    wet = (cfg.wet_mix > 16'd32768) ? 32768 : cfg.wet_mix;
    gain = cfg.feedback_gain;
    y.left = l_in;
    y.right = r_in;
    case (cfg.mode)
      MODE_STEREO, MODE_PINGPONG: begin
        dl = left_mem[tap(main_pos, cfg.left_delay, MAIN_DEPTH)];
        dr = right_mem[tap(main_pos, cfg.right_delay, MAIN_DEPTH)];
        fl = (cfg.mode == MODE_STEREO) ? dl : dr;
        fr = (cfg.mode == MODE_STEREO) ? dr : dl;
        left_mem[main_pos] = sample_t'(clip(xl + round_q15(fl * gain)));
        right_mem[main_pos] = sample_t'(clip(xr + round_q15(fr * gain)));
        y.left = sample_t'(blend(xl, dl, wet));
        y.right = sample_t'(blend(xr, dr, wet));
        main_pos = main_pos + 1'b1;
      end
      MODE_HAAS: begin
        avg = (xl + xr) >>> 1;
        dh = haas_mem[tap(haas_pos, cfg.haas_delay, HAAS_DEPTH)];
        haas_mem[haas_pos] = sample_t'(avg);
        y.left = sample_t'(avg);
        y.right = sample_t'(blend(avg, dh, wet));
        haas_pos = haas_pos + 1'b1;
      end
      default: ;  // bypass: nothing advances
    endcase
    return y;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg.mode = MODE_STEREO;
      cfg.left_delay = 17'd24000;
      cfg.right_delay = 17'd24000;
      cfg.haas_delay = 11'd480;
      cfg.feedback_gain = 15'd16384;
      cfg.wet_mix = 16'd16384;
      foreach (left_mem[i]) left_mem[i] = '0;
      foreach (right_mem[i]) right_mem[i] = '0;
      foreach (haas_mem[i]) haas_mem[i] = '0;
      main_pos = '0;
      haas_pos = '0;
      expected_pairs.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_MODE:      cfg.mode = pwdata[1:0];
          REG_LEFT_DLY:  cfg.left_delay = pwdata[16:0];
          REG_RIGHT_DLY: cfg.right_delay = pwdata[16:0];
          REG_HAAS_DLY:  cfg.haas_delay = pwdata[10:0];
          REG_FB_GAIN:   cfg.feedback_gain = pwdata[14:0];
          REG_WET_MIX:   cfg.wet_mix = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_pairs.push_back(process_pair(s_axis_tdata[SAMPLE_BITS-1:0],
                                              s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[2*SAMPLE_BITS-1:0];
        if (expected_pairs.size() == 0) begin
          errors++;
          $display("%0t: output word with nothing expected, got left %0d right %0d",
                   $time, got.left, got.right);
        end else begin
          want = expected_pairs.pop_front();
          checked++;
          if (got.left !== want.left) begin
            errors++;
            $display("%0t: left_out expected %0d, got %0d", $time, want.left, got.left);
          end
          if (got.right !== want.right) begin
            errors++;
            $display("%0t: right_out expected %0d, got %0d", $time, want.right, got.right);
          end
        end
      end
    end
    pending = expected_pairs.size();
  end

endmodule

// ===== tb/sv/stereo_feedback_delay_test.sv =====
// stereo_feedback_delay_test: drives registers and sample words into the delay and gives the verdict
`timescale 1ns / 1ps

module stereo_feedback_delay_test;
  import sfd_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t    SMAX        = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam sample_t    SMIN        = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic [1:0] MODE_BYPASS = 2'd3;
  localparam int         HOLD_CYCLES = 400;
  localparam int         RAND_PHASES = 17;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TDATA_W-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;

  int errors;
  int pending;
  int checked;
  int sent = 0;
  int settings = 0;
  int burst_left = 4;
  bit squeeze_req = 1'b0;
  bit squeeze_done = 1'b0;

  always #2 clk = ~clk;

  stereo_feedback_delay dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  stereo_delay_checker delay_check (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked)
  );

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [1:0] mode, input logic [16:0] ldly,
                           input logic [16:0] rdly, input logic [10:0] hdly,
                           input logic [14:0] gain, input logic [15:0] wet);
    reg_write(REG_MODE, 32'(mode));
    reg_write(REG_LEFT_DLY, 32'(ldly));
    reg_write(REG_RIGHT_DLY, 32'(rdly));
    reg_write(REG_HAAS_DLY, 32'(hdly));
    reg_write(REG_FB_GAIN, 32'(gain));
    reg_write(REG_WET_MIX, 32'(wet));
    settings++;
  endtask

  // stop sending and let every word in flight come out before touching registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_word(input sample_t l, input sample_t r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= TDATA_W'({r, l});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // gap with valid held low, so valid never drops and rises in one step
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 7);
    end
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return SMAX;
      1: return SMIN;
      2: return '0;
      3: return sample_t'($urandom_range(0, 511)) - sample_t'(256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int pick_delay(input int max_dly);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return max_dly;
      2: return $urandom_range(0, max_dly);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic logic [14:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 15'd0;
      1: return 15'h7fff;
      2: return 15'd31130;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [15:0] pick_wet();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(32769, 65535));
      3: return 16'hffff;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return MODE_STEREO;
    if (r < 6) return MODE_PINGPONG;
    if (r < 9) return MODE_HAAS;
    return MODE_BYPASS;
  endfunction

  // receiver: segments of differing stall density, plus one long hold-off
  initial begin
    int style;
    int seg_left;
    seg_left = 0;
    style = 0;
    forever begin
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          style = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 120);
        end
        seg_left--;
        case (style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 4) == 0);
          default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // stereo, short delays, top gain: line writes saturate
    configure(MODE_STEREO, 17'd1, 17'd2, 11'd1, 15'h7fff, 16'd32768);
    send_word(SMAX, SMIN);
    send_word(SMAX, SMIN);
    send_word(SMAX, SMIN);
    send_word(SMIN, SMAX);
    send_word('0, '0);
    send_word(sample_t'(-1), sample_t'(-1));
    settle();

    // ping-pong with wet above one, clamped to fully wet
    configure(MODE_PINGPONG, 17'd1, 17'd3, 11'd1, 15'd31130, 16'hffff);
    send_word(SMAX, '0);
    send_word('0, SMIN);
    send_word(SMIN, SMAX);
    send_word(SMAX, SMAX);
    send_word(sample_t'(12345), sample_t'(-54321));
    settle();

    // haas averaging, including floor of odd negative sums
    configure(MODE_HAAS, 17'd5, 17'd5, 11'd1, 15'd16384, 16'd16384);
    send_word(SMAX, SMAX);
    send_word(SMIN, SMIN);
    send_word(SMIN, SMAX);
    send_word(sample_t'(-1), '0);
    send_word(sample_t'(1), '0);
    settle();

    // mode three passes both inputs through untouched
    configure(MODE_BYPASS, 17'd1, 17'd1, 11'd1, 15'h7fff, 16'd32768);
    send_word(SMAX, SMIN);
    send_word(sample_t'(123), sample_t'(-456));
    settle();

    // zero delay and longest delays read entries never written in this run
    configure(MODE_STEREO, 17'd0, 17'h1ffff, 11'h7ff, 15'd0, 16'd32768);
    send_word(SMIN, SMAX);
    send_word(sample_t'(777), sample_t'(-777));
    send_word(sample_t'(-1), sample_t'(1));
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      configure(pick_mode(), 17'(pick_delay(131071)), 17'(pick_delay(131071)),
                11'(pick_delay(2047)), pick_gain(), pick_wet());
      n = $urandom_range(60, 140);
      if (p == 4) begin
        // long receiver hold-off while the sender keeps offering words
        squeeze_req = 1'b1;
        n = 200;
      end
      repeat (n) send_word(pick_sample(), pick_sample());
      settle();
    end

    // restore the reset register values at the end
    configure(MODE_STEREO, 17'd24000, 17'd24000, 11'd480, 15'd16384, 16'd16384);
    repeat (20) send_word(pick_sample(), pick_sample());
    settle();

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d sample words (%0d checked) over %0d register settings", sent,
             checked, settings);
    $display("modes stereo, ping-pong, haas and bypass; one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout: %0d words still expected", pending);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
